// ----- sv/bcca_pkg.sv -----
// Package for the bitmap cluster chain allocator.
// Holds widths, codes, payload structs, controller states and the
// command/status structs that join the controller and the datapath.
package bcca_pkg;

    localparam int CLUSTERS  = 4096;
    localparam int CL_W      = 12;
    localparam int CNT_W     = 13;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;
    localparam int WORDS     = CLUSTERS / WORD_W;
    localparam int WIDX_W    = 7;
    localparam int MODE_W    = 2;
    localparam int ST_W      = 2;
    localparam int AC_W      = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 13;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHECK = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED      = 1'd1;

    localparam logic [CNT_W-1:0] CLUSTER_COUNT_RST = 13'd4096;
    localparam logic [CL_W-1:0]  RESERVED_RST      = 12'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CL_W-1:0]   target_cluster;
        logic [CL_W-1:0]   prev_cluster;
        logic [AC_W-1:0]   alloc_count;
    } req_t;

    typedef struct packed {
        logic [CL_W-1:0]  cluster;
        logic             is_free;
        logic [CNT_W-1:0] freed_count;
        logic [ST_W-1:0]  status;
        logic             last;
    } rsp_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_A_RD,
        S_A_LOAD,
        S_A_FIND,
        S_A_LINK,
        S_RB_RD,
        S_RB_WAIT,
        S_RB_WR,
        S_OUT_RD,
        S_EMIT_RUN,
        S_F_RD,
        S_F_WR,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        KIND_RUN,
        KIND_ZERO,
        KIND_NOSPACE,
        KIND_FREE_OK,
        KIND_FREE_BAD,
        KIND_CHECK,
        KIND_BAD
    } kind_t;

    typedef struct packed {
        logic  clear_step;
        logic  load_item;
        logic  kind_we;
        kind_t kind;
        logic  a_start;
        logic  a_read;
        logic  a_load_buf;
        logic  a_claim;
        logic  a_link;
        logic  a_next_word;
        logic  rb_start;
        logic  run_read;
        logic  rb_read_bm;
        logic  rb_write;
        logic  rb_unlink;
        logic  out_start;
        logic  idx_inc;
        logic  f_start;
        logic  f_read;
        logic  f_write;
        logic  c_read;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              clr_last;
        logic              want_zero;
        logic              head_bad;
        logic              found;
        logic              word_beyond;
        logic              got_full;
        logic              idx_done;
        logic              idx_last;
        logic              cur_zero;
        logic              cur_bad;
        logic              out_free;
    } sts_t;

endpackage

// ----- sv/bcca_ctrl.sv -----
// Controller state machine of the cluster allocator.
// Depends on bcca_pkg; drives bcca_dp through cmd_t and reads sts_t.
module bcca_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  bcca_pkg::sts_t sts,
    output bcca_pkg::cmd_t cmd
);
    import bcca_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.mode)
                    MODE_ALLOC:
                    begin
                        if (sts.want_zero)
                        begin
                            cmd.kind_we = 1'b1;
                            cmd.kind    = KIND_ZERO;
                            state_next  = S_EMIT;
                        end
                        else
                        begin
                            cmd.a_start = 1'b1;
                            state_next  = S_A_RD;
                        end
                    end
                    MODE_FREE:
                    begin
                        cmd.f_start = 1'b1;
                        if (sts.head_bad)
                        begin
                            cmd.kind_we = 1'b1;
                            cmd.kind    = KIND_FREE_BAD;
                            state_next  = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_F_RD;
                        end
                    end
                    MODE_CHECK:
                    begin
                        cmd.c_read  = 1'b1;
                        cmd.kind_we = 1'b1;
                        cmd.kind    = KIND_CHECK;
                        state_next  = S_EMIT;
                    end
                    default:
                    begin
                        cmd.kind_we = 1'b1;
                        cmd.kind    = KIND_BAD;
                        state_next  = S_EMIT;
                    end
                endcase
            end
            S_A_RD:
            begin
                if (sts.word_beyond)
                begin
                    cmd.rb_start = 1'b1;
                    state_next   = S_RB_RD;
                end
                else
                begin
                    cmd.a_read = 1'b1;
                    state_next = S_A_LOAD;
                end
            end
            S_A_LOAD:
            begin
                cmd.a_load_buf = 1'b1;
                state_next     = S_A_FIND;
            end
            S_A_FIND:
            begin
                if (sts.found)
                begin
                    cmd.a_claim = 1'b1;
                    state_next  = S_A_LINK;
                end
                else
                begin
                    cmd.a_next_word = 1'b1;
                    state_next      = S_A_RD;
                end
            end
            S_A_LINK:
            begin
                cmd.a_link = 1'b1;
                if (sts.got_full)
                begin
                    cmd.out_start = 1'b1;
                    cmd.kind_we   = 1'b1;
                    cmd.kind      = KIND_RUN;
                    state_next    = S_OUT_RD;
                end
                else
                begin
                    state_next = S_A_FIND;
                end
            end
            S_RB_RD:
            begin
                if (sts.idx_done)
                begin
                    cmd.rb_unlink = 1'b1;
                    cmd.kind_we   = 1'b1;
                    cmd.kind      = KIND_NOSPACE;
                    state_next    = S_EMIT;
                end
                else
                begin
                    cmd.run_read = 1'b1;
                    state_next   = S_RB_WAIT;
                end
            end
            S_RB_WAIT:
            begin
                cmd.rb_read_bm = 1'b1;
                state_next     = S_RB_WR;
            end
            S_RB_WR:
            begin
                cmd.rb_write = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_RB_RD;
            end
            S_OUT_RD:
            begin
                cmd.run_read = 1'b1;
                state_next   = S_EMIT_RUN;
            end
            S_EMIT_RUN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.idx_inc  = 1'b1;
                    state_next   = sts.idx_last ? S_IDLE : S_OUT_RD;
                end
            end
            S_F_RD:
            begin
                if (sts.cur_zero)
                begin
                    cmd.kind_we = 1'b1;
                    cmd.kind    = KIND_FREE_OK;
                    state_next  = S_EMIT;
                end
                else if (sts.cur_bad)
                begin
                    cmd.kind_we = 1'b1;
                    cmd.kind    = KIND_FREE_BAD;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cmd.f_read = 1'b1;
                    state_next = S_F_WR;
                end
            end
            S_F_WR:
            begin
                cmd.f_write = 1'b1;
                state_next  = S_F_RD;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/bcca_dp.sv -----
// Datapath of the cluster allocator: config registers, bitmap, link and
// run memories, scan logic and the result register. Depends on bcca_pkg.
module bcca_dp #(
    parameter int MAX_RUN = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bcca_pkg::cmd_t                 cmd,
    output bcca_pkg::sts_t                 sts,
    input  bcca_pkg::req_t                 req_item,
    input  logic                           cfg_we,
    input  logic [bcca_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [bcca_pkg::CFG_W-1:0]     cfg_wdata,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output bcca_pkg::rsp_t                 rsp_item
);
    import bcca_pkg::*;

    localparam int RUN_CW = $clog2(MAX_RUN + 1);
    localparam int RUN_AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam logic [AC_W-1:0] MAX_RUN_AC = AC_W'(MAX_RUN);

    logic [CNT_W-1:0]  cnt_reg;
    logic [CL_W-1:0]   res_reg;
    logic [CL_W-1:0]   lre_reg;
    logic [WIDX_W-1:0] clr_reg;
    logic              rsp_valid_reg;

    logic [MODE_W-1:0] mode_reg;
    logic [CL_W-1:0]   target_reg;
    logic [CL_W-1:0]   prev0_reg;
    logic              want_zero_reg;
    logic [RUN_CW-1:0] want_reg;
    logic [WIDX_W:0]   widx_reg;
    logic [WORD_W-1:0] buf_reg;
    logic [CL_W-1:0]   prev_reg;
    logic [CL_W-1:0]   c_reg;
    logic [CL_W-1:0]   cur_reg;
    logic [CNT_W-1:0]  freed_reg;
    logic [RUN_CW-1:0] got_reg;
    logic [RUN_CW-1:0] idx_reg;
    kind_t             kind_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    logic [WORD_W-1:0] bm_mem [WORDS];
    logic [CL_W-1:0]   lk_mem [CLUSTERS];
    logic [CL_W-1:0]   run_mem [MAX_RUN];
    logic [WORD_W-1:0] bm_rdata_reg;
    logic [CL_W-1:0]   lk_rdata_reg;
    logic [CL_W-1:0]   run_rdata_reg;

    logic [CNT_W-1:0]  eff_cnt;
    logic [CL_W-1:0]   eff_res;
    logic [WORD_W-1:0] lo_mask;
    logic [WORD_W-1:0] hi_mask;
    logic [WORD_W-1:0] scan_word;
    logic [WORD_W-1:0] zero_oh;
    logic [BIT_W-1:0]  bitpos;
    logic [CL_W-1:0]   c_found;
    logic              bm_rd;
    logic [WIDX_W-1:0] bm_raddr;
    logic [AC_W-1:0]   want_sat;

    function automatic logic in_vol(logic [CL_W-1:0] c, logic [CL_W-1:0] r,
                                    logic [CNT_W-1:0] n);
        return (c >= r) && ({1'b0, c} < n);
    endfunction

    function automatic logic [WORD_W-1:0] bit_sel(logic [BIT_W-1:0] p);
        return WORD_W'(1) << p;
    endfunction

    assign eff_cnt = (cnt_reg > CNT_W'(CLUSTERS)) ? CNT_W'(CLUSTERS) : cnt_reg;
    assign eff_res = (res_reg == '0) ? CL_W'(1) : res_reg;

    always_comb
    begin
        if (widx_reg == {1'b0, eff_res[CL_W-1:BIT_W]})
        begin
            lo_mask = bit_sel(eff_res[BIT_W-1:0]) - WORD_W'(1);
        end
        else if (widx_reg < {1'b0, eff_res[CL_W-1:BIT_W]})
        begin
            lo_mask = '1;
        end
        else
        begin
            lo_mask = '0;
        end
        if (widx_reg == eff_cnt[CNT_W-1:BIT_W])
        begin
            hi_mask = ~(bit_sel(eff_cnt[BIT_W-1:0]) - WORD_W'(1));
        end
        else if (widx_reg > eff_cnt[CNT_W-1:BIT_W])
        begin
            hi_mask = '1;
        end
        else
        begin
            hi_mask = '0;
        end
    end

    // lowest clear bit of the masked word, isolated then encoded
    assign scan_word = buf_reg | lo_mask | hi_mask;
    assign zero_oh   = ~scan_word & (scan_word + WORD_W'(1));

    always_comb
    begin
        bitpos = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (zero_oh[i])
            begin
                bitpos = bitpos | BIT_W'(i);
            end
        end
    end

    assign c_found  = {widx_reg[WIDX_W-1:0], bitpos};
    assign want_sat = (req_item.alloc_count > MAX_RUN_AC) ? MAX_RUN_AC
                                                          : req_item.alloc_count;

    assign sts.mode        = mode_reg;
    assign sts.clr_last    = (clr_reg == WIDX_W'(WORDS - 1));
    assign sts.want_zero   = want_zero_reg;
    assign sts.head_bad    = !in_vol(target_reg, eff_res, eff_cnt);
    assign sts.found       = |zero_oh;
    assign sts.word_beyond = ({widx_reg, BIT_W'(0)} >= eff_cnt);
    assign sts.got_full    = (got_reg == want_reg);
    assign sts.idx_done    = (idx_reg == got_reg);
    assign sts.idx_last    = (RUN_CW'(idx_reg + RUN_CW'(1)) == got_reg);
    assign sts.cur_zero    = (cur_reg == '0);
    assign sts.cur_bad     = !in_vol(cur_reg, eff_res, eff_cnt) || (freed_reg >= eff_cnt);
    assign sts.out_free    = !rsp_valid_reg || rsp_ready;

    // bitmap memory
    assign bm_rd = cmd.a_read | cmd.rb_read_bm | cmd.f_read | cmd.c_read;

    always_comb
    begin
        if (cmd.a_read)
        begin
            bm_raddr = widx_reg[WIDX_W-1:0];
        end
        else if (cmd.rb_read_bm)
        begin
            bm_raddr = run_rdata_reg[CL_W-1:BIT_W];
        end
        else if (cmd.f_read)
        begin
            bm_raddr = cur_reg[CL_W-1:BIT_W];
        end
        else
        begin
            bm_raddr = target_reg[CL_W-1:BIT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            bm_mem[clr_reg] <= '0;
        end
        else if (cmd.a_claim)
        begin
            bm_mem[widx_reg[WIDX_W-1:0]] <= buf_reg | bit_sel(bitpos);
        end
        else if (cmd.rb_write || cmd.f_write)
        begin
            bm_mem[cur_reg[CL_W-1:BIT_W]] <= bm_rdata_reg & ~bit_sel(cur_reg[BIT_W-1:0]);
        end
        if (bm_rd)
        begin
            bm_rdata_reg <= bm_mem[bm_raddr];
        end
    end

    // link memory
    always_ff @(posedge clk)
    begin
        if (cmd.a_claim)
        begin
            lk_mem[c_found] <= '0;
        end
        else if (cmd.a_link && (prev_reg != '0))
        begin
            lk_mem[prev_reg] <= c_reg;
        end
        else if (cmd.rb_unlink && (prev0_reg != '0))
        begin
            lk_mem[prev0_reg] <= '0;
        end
        if (cmd.f_read)
        begin
            lk_rdata_reg <= lk_mem[cur_reg];
        end
    end

    // run memory
    always_ff @(posedge clk)
    begin
        if (cmd.a_claim)
        begin
            run_mem[got_reg[RUN_AW-1:0]] <= c_found;
        end
        if (cmd.run_read)
        begin
            run_rdata_reg <= run_mem[idx_reg[RUN_AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= CLUSTER_COUNT_RST;
            res_reg       <= RESERVED_RST;
            lre_reg       <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_CLUSTER_COUNT: cnt_reg <= cfg_wdata;
                    CFG_RESERVED:      res_reg <= cfg_wdata[CL_W-1:0];
                    default:           ;
                endcase
            end
            if (cmd.out_start)
            begin
                lre_reg <= c_reg;
            end
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + WIDX_W'(1);
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg      <= req_item.mode;
            target_reg    <= req_item.target_cluster;
            prev0_reg     <= (req_item.prev_cluster == '0) ? lre_reg
                                                           : req_item.prev_cluster;
            want_zero_reg <= (req_item.alloc_count == '0);
            want_reg      <= RUN_CW'(want_sat);
        end
        if (cmd.a_start)
        begin
            widx_reg <= {1'b0, eff_res[CL_W-1:BIT_W]};
        end
        else if (cmd.a_next_word)
        begin
            widx_reg <= widx_reg + (WIDX_W + 1)'(1);
        end
        if (cmd.a_load_buf)
        begin
            buf_reg <= bm_rdata_reg;
        end
        else if (cmd.a_claim)
        begin
            buf_reg <= buf_reg | bit_sel(bitpos);
        end
        if (cmd.a_start)
        begin
            got_reg <= '0;
        end
        else if (cmd.a_claim)
        begin
            got_reg <= got_reg + RUN_CW'(1);
        end
        if (cmd.a_start)
        begin
            prev_reg <= prev0_reg;
        end
        else if (cmd.a_link)
        begin
            prev_reg <= c_reg;
        end
        if (cmd.a_claim)
        begin
            c_reg <= c_found;
        end
        if (cmd.rb_start || cmd.out_start)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + RUN_CW'(1);
        end
        if (cmd.f_start)
        begin
            cur_reg <= target_reg;
        end
        else if (cmd.rb_read_bm)
        begin
            cur_reg <= run_rdata_reg;
        end
        else if (cmd.f_write)
        begin
            cur_reg <= lk_rdata_reg;
        end
        if (cmd.f_start)
        begin
            freed_reg <= '0;
        end
        else if (cmd.f_write)
        begin
            freed_reg <= freed_reg + CNT_W'(1);
        end
        if (cmd.kind_we)
        begin
            kind_reg <= cmd.kind;
        end
        if (cmd.out_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_comb
    begin
        rsp_next      = '0;
        rsp_next.last = 1'b1;
        case (kind_reg)
            KIND_RUN:
            begin
                rsp_next.cluster = run_rdata_reg;
                rsp_next.last    = sts.idx_last;
            end
            KIND_ZERO:
            begin
                rsp_next.status = ST_OK;
            end
            KIND_NOSPACE:
            begin
                rsp_next.status = ST_NO_SPACE;
            end
            KIND_FREE_OK:
            begin
                rsp_next.freed_count = freed_reg;
                rsp_next.status      = ST_OK;
            end
            KIND_FREE_BAD:
            begin
                rsp_next.freed_count = freed_reg;
                rsp_next.status      = ST_BAD;
            end
            KIND_CHECK:
            begin
                if ({1'b0, target_reg} >= eff_cnt)
                begin
                    rsp_next.status = ST_BAD;
                end
                else if (target_reg >= eff_res)
                begin
                    rsp_next.is_free = ~bm_rdata_reg[target_reg[BIT_W-1:0]];
                end
            end
            default:
            begin
                rsp_next.status = ST_BAD;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp_valid_reg || rsp_ready))
        else $error("result register overwritten while pending");

    a_claim_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.a_claim |-> (got_reg < want_reg))
        else $error("run grew past requested length");

    a_claim_in_vol: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.a_claim |-> in_vol(c_found, eff_res, eff_cnt))
        else $error("claimed cluster outside volume");

    a_free_in_vol: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.f_write |-> in_vol(cur_reg, eff_res, eff_cnt))
        else $error("free walk cleared cluster outside volume");
`endif

endmodule

// ----- sv/bitmap_cluster_chain_allocator_core.sv -----
// Top level of the bitmap cluster chain allocator.
// Depends on bcca_pkg, bcca_ctrl and bcca_dp.
//
// Requests enter on req_valid/req_ready with a req_t payload; results leave
// on rsp_valid/rsp_ready with an rsp_t payload. A transaction completes when
// valid and ready are both high at a rising edge. cfg_we/cfg_addr/cfg_wdata
// write cluster_count (0) and reserved_clusters (1); write only when idle.
// After reset the bitmap is cleared one 32-bit word per cycle: req_ready
// stays low until all 128 words are clear, then goes high.
// One request is worked on at a time; req_ready is high in the idle state.
// Check: the bitmap word is read in the dispatch state and the result is
// loaded in the emit state. Free: each cluster walked is read, then its bit
// is cleared and its link followed. Allocate: each bitmap word scanned is
// read, loaded and searched, each clear bit found is claimed and linked,
// then each result is read out; a failed run rolls back each claim.
// A single result register sits on the output; while it is stalled the
// block holds its state, and after the final result of a request it
// accepts the next request even if that result has not yet been taken.
module bitmap_cluster_chain_allocator_core #(
    parameter int MAX_RUN = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  bcca_pkg::req_t                 req_item,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output bcca_pkg::rsp_t                 rsp_item,
    input  logic                           cfg_we,
    input  logic [bcca_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [bcca_pkg::CFG_W-1:0]     cfg_wdata
);
    import bcca_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bcca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bcca_dp #(
        .MAX_RUN (MAX_RUN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_item  (req_item),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for bitmap_cluster_chain_allocator_core.
// Depends on bcca_pkg; a directed table, then random phases per volume setting,
// each result checked against a fixed answer or an in-bench model of the bitmap and link store.
module testbench;

    import bcca_pkg::*;

    localparam int RUN_MAX     = 64;
    localparam int SIDE_TX     = 0;
    localparam int SIDE_RX     = 1;
    localparam int HOLD_AFTER  = 150;
    localparam int HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES = 40;
    // ~360 transactions; allows every one a full 64-result run with worst stalls
    // plus bitmap scans, several times over
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASES      = 6;

    localparam logic [MODE_W-1:0] MODE_ILLEGAL = 2'd3;

    typedef struct {
        bit   is_volume;
        int   count;
        int   reserved;
        req_t req;
        bit   fixed;
        rsp_t answer;
    } plan_row_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_t                 req_item  = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_t                 rsp_item;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = CFG_CLUSTER_COUNT;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // model of the volume
    bit               used_map [CLUSTERS];
    logic [CL_W-1:0]  link_map [CLUSTERS];
    bit               link_set [CLUSTERS];
    logic [CL_W-1:0]  run_tail     = '0;
    logic [CNT_W-1:0] vol_count    = CLUSTER_COUNT_RST;
    logic [CL_W-1:0]  vol_reserved = RESERVED_RST;

    rsp_t computed [$];
    rsp_t owed_results [$];
    int   run_heads [$];
    int   calm_left [2] = '{0, 0};
    int   mismatches    = 0;
    int   results_taken = 0;
    int   cycles        = 0;

    int phase_count    [PHASES] = '{4096, 64, 8191, 4096, 1, 300};
    int phase_reserved [PHASES] = '{2, 4, 0, 4095, 1, 150};
    int phase_items    [PHASES] = '{100, 95, 40, 20, 10, 70};

    bitmap_cluster_chain_allocator_core #(
        .MAX_RUN (RUN_MAX)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int vol_limit();
        return (vol_count > CLUSTERS) ? CLUSTERS : int'(vol_count);
    endfunction

    function automatic int vol_floor();
        return (vol_reserved == 0) ? 1 : int'(vol_reserved);
    endfunction

    function automatic bit in_vol(input int c);
        return c >= vol_floor() && c < vol_limit();
    endfunction

    // fills computed[] with the results of one transaction and updates the volume model
    function automatic void compute_cluster_results(input req_t r);
        int   want;
        int   prev;
        int   first_prev;
        int   c;
        int   s;
        int   cur;
        int   freed;
        int   lim;
        bit   full;
        int   run [$];
        rsp_t res;
        computed.delete();
        res      = '0;
        res.last = 1'b1;
        case (r.mode)
            MODE_ALLOC:
            begin
                want = r.alloc_count;
                if (want == 0)
                begin
                    computed.push_back(res);
                    return;
                end
                if (want > RUN_MAX)
                    want = RUN_MAX;
                prev       = (r.prev_cluster == 0) ? int'(run_tail) : int'(r.prev_cluster);
                first_prev = prev;
                full       = 1'b0;
                while (run.size() < want && !full)
                begin
                    c = 0;
                    for (s = vol_floor(); s < vol_limit() && c == 0; s++)
                    begin
                        if (!used_map[s])
                            c = s;
                    end
                    if (c == 0)
                        full = 1'b1;
                    else
                    begin
                        used_map[c] = 1'b1;
                        link_map[c] = '0;
                        link_set[c] = 1'b1;
                        if (prev != 0)
                        begin
                            link_map[prev] = CL_W'(c);
                            link_set[prev] = 1'b1;
                        end
                        prev = c;
                        run.push_back(c);
                    end
                end
                if (full)
                begin
                    foreach (run[k])
                        used_map[run[k]] = 1'b0;
                    if (first_prev != 0)
                    begin
                        link_map[first_prev] = '0;
                        link_set[first_prev] = 1'b1;
                    end
                    res.status = ST_NO_SPACE;
                    computed.push_back(res);
                end
                else
                begin
                    run_tail = CL_W'(run[run.size() - 1]);
                    run_heads.push_back(run[0]);
                    if (run_heads.size() > 48)
                        void'(run_heads.pop_front());
                    foreach (run[k])
                    begin
                        res.cluster = CL_W'(run[k]);
                        res.last    = (k == run.size() - 1);
                        computed.push_back(res);
                    end
                end
            end
            MODE_FREE:
            begin
                cur   = r.target_cluster;
                freed = 0;
                lim   = vol_limit();
                if (!in_vol(cur))
                    res.status = ST_BAD;
                else
                begin
                    while (cur != 0 && res.status == ST_OK)
                    begin
                        if (!in_vol(cur) || freed >= lim)
                            res.status = ST_BAD;
                        else
                        begin
                            used_map[cur] = 1'b0;
                            freed++;
                            cur = link_map[cur];
                        end
                    end
                    res.freed_count = CNT_W'(freed);
                end
                computed.push_back(res);
            end
            MODE_CHECK:
            begin
                if (r.target_cluster >= vol_limit())
                    res.status = ST_BAD;
                else if (r.target_cluster >= vol_floor())
                    res.is_free = !used_map[r.target_cluster];
                computed.push_back(res);
            end
            default:
            begin
                res.status = ST_BAD;
                computed.push_back(res);
            end
        endcase
    endfunction

    function automatic int idle_cycles(input int side);
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left[side] = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   pick;
        int   k;
        r.mode           = MODE_CHECK;
        r.target_cluster = CL_W'($urandom_range(0, CLUSTERS - 1));
        r.prev_cluster   = CL_W'($urandom_range(0, CLUSTERS - 1));
        r.alloc_count    = AC_W'($urandom_range(0, 127));
        pick             = $urandom_range(0, 99);
        if (pick < 45)
        begin
            r.mode = MODE_ALLOC;
            k      = $urandom_range(0, 19);
            if (k == 0)
                r.alloc_count = '0;
            else if (k == 1)
                r.alloc_count = AC_W'($urandom_range(RUN_MAX, 127));
            else
                r.alloc_count = AC_W'($urandom_range(1, 8));
            k = $urandom_range(0, 9);
            if (k < 7)
                r.prev_cluster = '0;
            else if (k < 9 && run_heads.size() > 0)
                r.prev_cluster = CL_W'(run_heads[$urandom_range(0, run_heads.size() - 1)]);
        end
        else if (pick < 75)
        begin
            r.mode = MODE_FREE;
            if (run_heads.size() > 0 && $urandom_range(0, 4) != 0)
            begin
                k                = $urandom_range(0, run_heads.size() - 1);
                r.target_cluster = CL_W'(run_heads[k]);
                run_heads.delete(k);
            end
            // only the head's link can be unwritten; later links name claimed clusters
            if (in_vol(r.target_cluster) && !link_set[r.target_cluster])
                r.mode = MODE_CHECK;
        end
        else if (pick < 95)
        begin
            if ($urandom_range(0, 1) == 1)
                r.target_cluster = CL_W'($urandom_range(0, vol_limit() + 2));
        end
        else
            r.mode = MODE_ILLEGAL;
        return r;
    endfunction

    function automatic plan_row_t ask(input logic [MODE_W-1:0] m, input int t, input int p,
                                      input int n);
        plan_row_t row;
        row.is_volume          = 1'b0;
        row.count              = 0;
        row.reserved           = 0;
        row.fixed              = 1'b0;
        row.answer             = '0;
        row.req.mode           = m;
        row.req.target_cluster = CL_W'(t);
        row.req.prev_cluster   = CL_W'(p);
        row.req.alloc_count    = AC_W'(n);
        return row;
    endfunction

    function automatic plan_row_t ask_known(input logic [MODE_W-1:0] m, input int t,
                                            input int p, input int n, input int cl,
                                            input bit fr, input logic [ST_W-1:0] st);
        plan_row_t row;
        row                = ask(m, t, p, n);
        row.fixed          = 1'b1;
        row.answer.cluster = CL_W'(cl);
        row.answer.is_free = fr;
        row.answer.status  = st;
        row.answer.last    = 1'b1;
        return row;
    endfunction

    function automatic plan_row_t volume(input int count, input int reserved);
        plan_row_t row;
        row           = ask(MODE_CHECK, 0, 0, 0);
        row.is_volume = 1'b1;
        row.count     = count;
        row.reserved  = reserved;
        return row;
    endfunction

    task automatic send_request(input req_t r, input bit fixed, input rsp_t answer);
        int gap;
        gap = idle_cycles(SIDE_TX);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_item  <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        compute_cluster_results(r);
        if (fixed)
            owed_results.push_back(answer);
        else
            foreach (computed[k])
                owed_results.push_back(computed[k]);
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_volume(input int count, input int reserved);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_CLUSTER_COUNT;
        cfg_wdata <= CFG_W'(count);
        @(posedge clk);
        cfg_addr  <= CFG_RESERVED;
        cfg_wdata <= CFG_W'(reserved);
        @(posedge clk);
        cfg_we       <= 1'b0;
        vol_count    = CNT_W'(count);
        vol_reserved = CL_W'(reserved);
    endtask

    initial
    begin : result_sink
        int   gap;
        bit   held;
        rsp_t got;
        rsp_t want;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = idle_cycles(SIDE_RX);
            if (!held && results_taken >= HOLD_AFTER)
            begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            got = rsp_item;
            results_taken++;
            if (owed_results.size() == 0)
            begin
                $error("unexpected result transaction: cluster %0d status %0d",
                       got.cluster, got.status);
                mismatches++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (got.cluster !== want.cluster)
                begin
                    $error("cluster: expected %0d, got %0d", want.cluster, got.cluster);
                    mismatches++;
                end
                if (got.is_free !== want.is_free)
                begin
                    $error("is_free: expected %0d, got %0d", want.is_free, got.is_free);
                    mismatches++;
                end
                if (got.freed_count !== want.freed_count)
                begin
                    $error("freed_count: expected %0d, got %0d", want.freed_count,
                           got.freed_count);
                    mismatches++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        plan_row_t plan [$];
        int        p;
        // reset settings: 4096 clusters, 2 reserved
        plan.push_back(ask_known(MODE_CHECK, 0, 0, 0, 0, 1'b0, ST_OK));
        plan.push_back(ask_known(MODE_CHECK, 1, 0, 0, 0, 1'b0, ST_OK));
        plan.push_back(ask_known(MODE_CHECK, 4095, 0, 0, 0, 1'b1, ST_OK));
        plan.push_back(ask_known(MODE_ILLEGAL, 4095, 4095, 127, 0, 1'b0, ST_BAD));
        plan.push_back(ask_known(MODE_ALLOC, 4095, 0, 0, 0, 1'b0, ST_OK));
        plan.push_back(ask_known(MODE_ALLOC, 0, 0, 1, 2, 1'b0, ST_OK));
        plan.push_back(ask(MODE_ALLOC, 0, 4095, 127));
        plan.push_back(ask(MODE_FREE, 4095, 0, 0));
        plan.push_back(ask_known(MODE_FREE, 0, 0, 0, 0, 1'b0, ST_BAD));
        plan.push_back(ask_known(MODE_FREE, 1, 0, 0, 0, 1'b0, ST_BAD));
        // reserved count of zero acts as one
        plan.push_back(volume(16, 0));
        plan.push_back(ask_known(MODE_CHECK, 16, 0, 0, 0, 1'b0, ST_BAD));
        plan.push_back(ask_known(MODE_ALLOC, 0, 0, 15, 0, 1'b0, ST_NO_SPACE));
        plan.push_back(ask(MODE_ALLOC, 0, 2, 14));
        plan.push_back(ask(MODE_FREE, 2, 0, 0));
        // single-cluster run linked after itself; the free walk runs until the count
        plan.push_back(ask(MODE_ALLOC, 0, 1, 1));
        plan.push_back(ask(MODE_FREE, 1, 0, 0));
        plan.push_back(volume(8191, 2));
        plan.push_back(ask_known(MODE_CHECK, 4095, 0, 0, 0, 1'b1, ST_OK));
        plan.push_back(ask(MODE_ALLOC, 0, 0, 4));
        // shrink the volume so the chain leaves it
        plan.push_back(volume(5, 2));
        plan.push_back(ask_known(MODE_FREE, 5, 0, 0, 0, 1'b0, ST_BAD));
        plan.push_back(ask(MODE_FREE, 2, 0, 0));
        plan.push_back(ask(MODE_ALLOC, 0, 0, 2));
        plan.push_back(ask(MODE_ALLOC, 0, 0, 2));
        plan.push_back(volume(0, 4095));
        plan.push_back(ask_known(MODE_CHECK, 0, 0, 0, 0, 1'b0, ST_BAD));
        plan.push_back(ask_known(MODE_ALLOC, 0, 0, 1, 0, 1'b0, ST_NO_SPACE));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_volume)
            begin
                settle();
                set_volume(plan[i].count, plan[i].reserved);
            end
            else
                send_request(plan[i].req, plan[i].fixed, plan[i].answer);
        end

        for (p = 0; p < PHASES; p++)
        begin
            settle();
            set_volume(phase_count[p], phase_reserved[p]);
            repeat (phase_items[p])
                send_request(random_request(), 1'b0, '0);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
sv/bcca_pkg.sv
sv/bcca_ctrl.sv
sv/bcca_dp.sv
sv/bitmap_cluster_chain_allocator_core.sv
verif/testbench.sv
